### design/lcbp_pkg.sv
package lcbp_pkg;

  // memory sizes (powers of two, so address wrap is a bit mask)
  localparam int TEXT_DEPTH  = 64;
  localparam int GLYPH_DEPTH = 128;
  localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
  localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // command codes
  localparam logic [7:0] OP_CLEAR    = 8'h07;
  localparam logic [7:0] OP_TEXT     = 8'hC0;
  localparam logic [7:0] OP_GLYPH    = 8'hD0;
  localparam logic [7:0] OP_SHIFT_LO = 8'h48;
  localparam logic [7:0] OP_SHIFT_HI = 8'h4F;
  localparam logic [7:0] SPACE_CODE  = 8'h20;

  // collection layout: slot 1 holds the position, data from slot 2 on
  localparam logic [2:0] TEXT_BYTES_LEFT  = 3'd6;
  localparam logic [2:0] GLYPH_BYTES_LEFT = 3'd7;
  localparam logic [2:0] FIRST_INDEX      = 3'd1;
  localparam logic [2:0] POS_INDEX        = 3'd1;
  localparam logic [2:0] DATA_BASE        = 3'd2;
  localparam logic [2:0] TEXT_LEN         = 3'd5;
  localparam logic [2:0] GLYPH_LEN        = 3'd6;

  typedef enum logic [1:0] {
    MODE_CMD      = 2'd0,
    MODE_TEXT_RD  = 2'd1,
    MODE_GLYPH_RD = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    JOB_NOP,
    JOB_RD_TEXT,
    JOB_RD_GLYPH,
    JOB_CLEAR,
    JOB_STASH,
    JOB_FIRE_TEXT,
    JOB_FIRE_GLYPH
  } job_e;

  // one classified item on its way to the back end
  typedef struct packed {
    job_e        job;
    logic [6:0]  addr;   // read address, or buffer slot for stash/fire
    logic [7:0]  data;
    logic [2:0]  shift;  // shift setting after this item
    logic        recv;   // collecting flag after this item
  } job_t;

  function automatic logic [TEXT_AW-1:0] text_idx(input logic [8:0] v);
    return TEXT_AW'(v % TEXT_DEPTH);
  endfunction

  function automatic logic [GLYPH_AW-1:0] glyph_idx(input logic [8:0] v);
    return GLYPH_AW'(v % GLYPH_DEPTH);
  endfunction

endpackage

### design/lcbp_ram.sv
module lcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/lcbp_front.sv
module lcbp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        byte_i,
  input  logic [6:0]        addr_i,
  input  logic              q_full_i,
  output logic              push_o,
  output lcbp_pkg::job_t    job_o
);

  logic       collecting_q, collecting_d;
  logic       glyph_q, glyph_d;
  logic [2:0] shift_q, shift_d;
  logic [2:0] left_q, left_d;
  logic [2:0] widx_q, widx_d;
  lcbp_pkg::job_e job;
  logic [6:0] job_addr;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classify the item and work out the next parser state
  always_comb begin
    collecting_d = collecting_q;
    glyph_d      = glyph_q;
    shift_d      = shift_q;
    left_d       = left_q;
    widx_d       = widx_q;
    job          = lcbp_pkg::JOB_NOP;
    job_addr     = addr_i;
    case (mode_i)
      lcbp_pkg::MODE_CMD: begin
        if (collecting_q) begin
          // every byte is data while collecting
          left_d   = left_q - 3'd1;
          widx_d   = widx_q + 3'd1;
          job_addr = {4'b0, widx_q};
          if (left_q == 3'd1) begin
            collecting_d = 1'b0;
            job = glyph_q ? lcbp_pkg::JOB_FIRE_GLYPH : lcbp_pkg::JOB_FIRE_TEXT;
          end else begin
            job = lcbp_pkg::JOB_STASH;
          end
        end else if (byte_i == lcbp_pkg::OP_CLEAR) begin
          shift_d = 3'd0;
          job     = lcbp_pkg::JOB_CLEAR;
        end else if (byte_i inside {[lcbp_pkg::OP_SHIFT_LO:lcbp_pkg::OP_SHIFT_HI]}) begin
          shift_d = byte_i[2:0];
        end else if (byte_i == lcbp_pkg::OP_TEXT || byte_i == lcbp_pkg::OP_GLYPH) begin
          collecting_d = 1'b1;
          glyph_d      = (byte_i == lcbp_pkg::OP_GLYPH);
          left_d       = (byte_i == lcbp_pkg::OP_GLYPH) ? lcbp_pkg::GLYPH_BYTES_LEFT
                                                        : lcbp_pkg::TEXT_BYTES_LEFT;
          widx_d       = lcbp_pkg::FIRST_INDEX;
        end
      end
      lcbp_pkg::MODE_TEXT_RD:  job = lcbp_pkg::JOB_RD_TEXT;
      lcbp_pkg::MODE_GLYPH_RD: job = lcbp_pkg::JOB_RD_GLYPH;
      default:                 job = lcbp_pkg::JOB_NOP;
    endcase
  end

  assign job_o = '{job: job, addr: job_addr, data: byte_i, shift: shift_d,
                   recv: collecting_d};

  // parser state advances on every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      glyph_q      <= 1'b0;
      shift_q      <= 3'd0;
      left_q       <= 3'd0;
      widx_q       <= 3'd0;
    end else if (push_o) begin
      collecting_q <= collecting_d;
      glyph_q      <= glyph_d;
      shift_q      <= shift_d;
      left_q       <= left_d;
      widx_q       <= widx_d;
    end
  end

endmodule

### design/lcbp_queue.sv
module lcbp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcbp_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output lcbp_pkg::job_t job_o
);

  lcbp_pkg::job_t                  mem_q [lcbp_pkg::QUEUE_DEPTH];
  logic [lcbp_pkg::QUEUE_AW-1:0]   wptr_q, rptr_q;
  logic [lcbp_pkg::QUEUE_AW:0]     cnt_q;

  assign full_o  = (cnt_q == (lcbp_pkg::QUEUE_AW+1)'(lcbp_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rptr_q];

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

### design/lcbp_back.sv
module lcbp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  lcbp_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_data_o,
  output logic [2:0]     out_shift_o,
  output logic           out_recv_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_BURST} state_e;

  state_e     state_q;
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic [2:0] out_shift_q;
  logic       out_recv_q;
  logic       rd_valid_q;
  logic       rd_glyph_q;
  logic       burst_glyph_q;
  logic [2:0] cnt_q;
  logic [7:0] buf_q [8];
  logic [lcbp_pkg::TEXT_DEPTH-1:0]  tvalid_q;
  logic [lcbp_pkg::GLYPH_DEPTH-1:0] gvalid_q;

  logic       out_free;
  logic       out_set;
  logic [8:0] burst_pos;
  logic [7:0] burst_data;
  logic [2:0] burst_last;
  logic [lcbp_pkg::TEXT_AW-1:0]  t_raddr, t_waddr;
  logic [lcbp_pkg::GLYPH_AW-1:0] g_raddr, g_waddr;
  logic       t_re, t_we, g_re, g_we;
  logic [7:0] t_rdata, g_rdata;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i && out_free;

  // a result is ready at once for most jobs, and for reads from the ST_READ state that follows the pop
  assign out_set = (state_q == ST_READ) ||
                   (pop_o && !(job_i.job inside {lcbp_pkg::JOB_RD_TEXT,
                                                 lcbp_pkg::JOB_RD_GLYPH}));

  // burst address and data come from the collected bytes
  assign burst_pos  = {1'b0, buf_q[lcbp_pkg::POS_INDEX]} + {6'b0, cnt_q};
  assign burst_data = buf_q[cnt_q + lcbp_pkg::DATA_BASE];
  assign burst_last = (burst_glyph_q ? lcbp_pkg::GLYPH_LEN : lcbp_pkg::TEXT_LEN) - 3'd1;

  assign t_raddr = lcbp_pkg::text_idx({2'b0, job_i.addr});
  assign g_raddr = lcbp_pkg::glyph_idx({2'b0, job_i.addr});
  assign t_waddr = lcbp_pkg::text_idx(burst_pos);
  assign g_waddr = lcbp_pkg::glyph_idx(burst_pos);
  assign t_re    = pop_o && (job_i.job == lcbp_pkg::JOB_RD_TEXT);
  assign g_re    = pop_o && (job_i.job == lcbp_pkg::JOB_RD_GLYPH);
  assign t_we    = (state_q == ST_BURST) && !burst_glyph_q;
  assign g_we    = (state_q == ST_BURST) && burst_glyph_q;

  lcbp_ram #(.WIDTH(8), .DEPTH(lcbp_pkg::TEXT_DEPTH)) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (burst_data),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  lcbp_ram #(.WIDTH(8), .DEPTH(lcbp_pkg::GLYPH_DEPTH)) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (burst_data),
    .re_i    (g_re),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  // collected bytes, no reset
  always_ff @(posedge clk_i) begin
    if (pop_o && (job_i.job inside {lcbp_pkg::JOB_STASH, lcbp_pkg::JOB_FIRE_TEXT,
                                    lcbp_pkg::JOB_FIRE_GLYPH})) begin
      buf_q[job_i.addr[2:0]] <= job_i.data;
    end
  end

  // result valid: set when a result is ready, dropped once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_set) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // job sequencer, valid bits and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_data_q    <= 8'h00;
      out_shift_q   <= 3'd0;
      out_recv_q    <= 1'b0;
      tvalid_q      <= '0;
      gvalid_q      <= '0;
      rd_valid_q    <= 1'b0;
      rd_glyph_q    <= 1'b0;
      burst_glyph_q <= 1'b0;
      cnt_q         <= 3'd0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            out_shift_q <= job_i.shift;
            out_recv_q  <= job_i.recv;
            out_data_q  <= 8'h00;
            case (job_i.job)
              lcbp_pkg::JOB_RD_TEXT: begin
                rd_valid_q <= tvalid_q[t_raddr];
                rd_glyph_q <= 1'b0;
                state_q    <= ST_READ;
              end
              lcbp_pkg::JOB_RD_GLYPH: begin
                rd_valid_q <= gvalid_q[g_raddr];
                rd_glyph_q <= 1'b1;
                state_q    <= ST_READ;
              end
              lcbp_pkg::JOB_CLEAR: begin
                tvalid_q <= '0;
                gvalid_q <= '0;
              end
              lcbp_pkg::JOB_FIRE_TEXT, lcbp_pkg::JOB_FIRE_GLYPH: begin
                burst_glyph_q <= (job_i.job == lcbp_pkg::JOB_FIRE_GLYPH);
                cnt_q         <= 3'd0;
                state_q       <= ST_BURST;
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          // unwritten entries read as their reset value
          if (rd_valid_q) out_data_q <= rd_glyph_q ? g_rdata : t_rdata;
          else            out_data_q <= rd_glyph_q ? 8'h00 : lcbp_pkg::SPACE_CODE;
          state_q <= ST_IDLE;
        end
        ST_BURST: begin
          if (burst_glyph_q) gvalid_q[g_waddr] <= 1'b1;
          else               tvalid_q[t_waddr] <= 1'b1;
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == burst_last) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_shift_o = out_shift_q;
  assign out_recv_o  = out_recv_q;

endmodule

### design/lcd_command_byte_parser_unit.sv
// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: mode; tdata: byte_value, read_address
// m_axis   | out | m_axis_tvalid/m_axis_tready  | read_data, shift_value, receiving
//
// The front end takes one item per cycle while the two-entry job queue has room.
// The back end handles most items straight from its idle state, a memory read
// through a read state (registered RAM port), and the byte closing a write
// command through a burst state that writes one memory byte per cycle.
// Reset is asynchronous, active low; both memories read as reset contents at once
// through per-entry valid bits, so no clearing pass is needed.
// A stalled result holds the back end; the front keeps accepting until the queue fills.
module lcd_command_byte_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // byte_value[7:0], read_address[14:8]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // read_data[7:0], shift_value[10:8], receiving[11]
);

  logic           q_push, q_pop, q_full, q_empty;
  lcbp_pkg::job_t front_job, back_job;
  logic [7:0]     read_data;
  logic [2:0]     shift_value;
  logic           receiving;

  lcbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tuser),
    .byte_i     (s_axis_tdata[7:0]),
    .addr_i     (s_axis_tdata[14:8]),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (front_job)
  );

  lcbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .job_o   (back_job)
  );

  lcbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .job_i       (back_job),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (read_data),
    .out_shift_o (shift_value),
    .out_recv_o  (receiving)
  );

  assign m_axis_tdata = {4'b0, receiving, shift_value, read_data};

`ifndef SYNTH
  // the front never writes a job into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // the back end never takes a job from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");
`endif

endmodule
